// ===== design/boae_pkg.sv =====
// Package for the bistable oscillator audio effect.
// Holds the number formats, register indexes, sequencer and product codes.
// Used by the top level; no dependencies of its own.
package boae_pkg;

  // Width of registers, state and intermediate values (signed Q16.32 by default).
  localparam int DATA_BITS     = 48;
  // Channel field width and the number of codes it can carry.
  localparam int CHANNEL_BITS  = 4;
  localparam int CHANNEL_CODES = 16;
  // The shared multiplier takes DIGIT_BITS of one operand per cycle.
  localparam int DIGIT_BITS    = 24;
  localparam int DIGITS        = DATA_BITS / DIGIT_BITS;

  // Defaults for the top level parameters.
  localparam int DEF_CHANNELS    = 16;
  localparam int DEF_SAMPLE_BITS = 24;
  localparam int DEF_FRAC_BITS   = 32;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INPUT_GAIN      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_PREV_INPUT = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_PREV_DISP  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_OLDER_DISP = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_CUBIC      = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VELOCITY_SCALE  = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OUTPUT_GAIN     = 3'd6;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_MUL,
    ST_FIN,
    ST_SUMSAT,
    ST_DIFF,
    ST_CONV,
    ST_DONE
  } state_t;

  // Products formed by the shared multiplier, in the order they are run.
  typedef enum logic [3:0] {
    PR_IN,    // sample times input gain
    PR_SQ,    // x1 squared
    PR_CUBE,  // x1 cubed
    PR_CCUB,  // cubic weight times cube
    PR_CIN,   // previous input weight times u1
    PR_CPD,   // last displacement weight times x1
    PR_COD,   // older displacement weight times x2
    PR_VEL,   // displacement difference times velocity scale
    PR_OUT    // velocity times output gain
  } prod_t;

endpackage

// ===== design/bistable_oscillator_audio_effect.sv =====
// Top level of the bistable oscillator audio effect: a per-channel
// finite-difference Duffing-type oscillator. Depends on boae_pkg and boae_ram.
//
// Each input item carries a channel number and a signed audio sample and
// produces exactly one result item with the same channel number, the output
// sample and a clip flag. All arithmetic runs on one shared 48 by 24 bit
// multiplier under a small sequencer, so the block takes one item at a time:
// s_tready is high only while the sequencer is idle and out of reset. Between
// one acceptance and the next an item passes through the idle state, in which
// it is accepted, a read of the channel state from its RAM, nine products
// (each an operand load, one multiplier pass per digit of the operand, round
// and saturate), the sum and the difference saturation, and the output
// conversion with the final step that loads the result into the output. The
// result waits in an output register, so a new item may be accepted while it
// is still unread; the sequencer only stalls at its last step if the previous
// result has not been taken. Channel state (previous scaled input and the two
// last displacements) lives in one RAM row per channel; a valid bit per row,
// cleared by reset, makes an unwritten row read as zero, so no clearing pass
// is needed after reset. A channel number at or above CHANNELS uses the row
// of that number modulo CHANNELS. Configuration registers are written
// through cfg_we, cfg_index and cfg_data and must only change while the
// block is idle; writes to unknown indexes are ignored.
module bistable_oscillator_audio_effect #(
  parameter int CHANNELS    = boae_pkg::DEF_CHANNELS,
  parameter int SAMPLE_BITS = boae_pkg::DEF_SAMPLE_BITS,
  parameter int FRAC_BITS   = boae_pkg::DEF_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,

  // Input stream. s_tdata from bit 0 up: channel, sample_in, zero padding.
  input  logic                                                     s_tvalid,
  output logic                                                     s_tready,
  input  logic [((boae_pkg::CHANNEL_BITS + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,

  // Output stream. m_tdata from bit 0 up: channel_out, sample_out, zero padding.
  // m_tuser: clipped.
  output logic                                                     m_tvalid,
  input  logic                                                     m_tready,
  output logic [((boae_pkg::CHANNEL_BITS + SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  output logic                                                     m_tuser,

  // Configuration write port.
  input  logic                                   cfg_we,
  input  logic [boae_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [boae_pkg::DATA_BITS-1:0]         cfg_data
);

  localparam int DW      = boae_pkg::DATA_BITS;
  localparam int CB      = boae_pkg::CHANNEL_BITS;
  localparam int DGB     = boae_pkg::DIGIT_BITS;
  localparam int NDIG    = boae_pkg::DIGITS;
  localparam int DIG_W   = NDIG > 1 ? $clog2(NDIG) : 1;
  localparam int IDX_W   = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
  localparam int ACC_W   = 2 * DW;
  localparam int SUM_W   = DW + 2;
  localparam int IN_SH   = SAMPLE_BITS - 1;
  localparam int OUT_SH  = FRAC_BITS - (SAMPLE_BITS - 1);
  localparam int OUT_LSH = OUT_SH < 0 ? -OUT_SH : 0;
  localparam int RM_W    = DW + 1 + OUT_LSH;
  localparam int ROW_W   = 3 * DW;

  localparam logic [DW-1:0] MAG_POS = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MAG_NEG = {1'b1, {(DW-1){1'b0}}};

  // Saturate a wide two's complement value to DW bits.
  function automatic logic [DW-1:0] sat_data(input logic [SUM_W-1:0] v);
    logic [DW-1:0] r;
    r = v[DW-1:0];
    if (v[SUM_W-1] && (v[SUM_W-2:DW-1] != '1)) begin
      r = MAG_NEG;
    end else if (!v[SUM_W-1] && (v[SUM_W-2:DW-1] != '0)) begin
      r = MAG_POS;
    end
    return r;
  endfunction

  // Magnitude of a DW-bit two's complement value; the most negative value fits.
  function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] v);
    return v[DW-1] ? (DW'(0) - v) : v;
  endfunction

  // Configuration registers.
  logic [DW-1:0] input_gain, coef_prev_input, coef_prev_disp, coef_older_disp;
  logic [DW-1:0] coef_cubic, velocity_scale, output_gain;

  // Sequencer.
  boae_pkg::state_t state, state_next;
  boae_pkg::prod_t  prod, prod_next;
  logic             done_fire;
  logic             in_fire;

  // Item and channel state.
  logic [CB-1:0]          chan_r;
  logic [SAMPLE_BITS-1:0] smp_r;
  logic [IDX_W-1:0]       ci;
  logic [CHANNELS-1:0]    row_valid;
  logic [DW-1:0]          u1, x1, x2;
  logic [DW-1:0]          u_new, x0, t;
  logic [SUM_W-1:0]       sum;

  // Shared multiplier datapath.
  logic [DW-1:0]       opa, opb;
  logic [DW-1:0]       ma, mb;
  logic                pneg;
  logic                sh_in;
  logic [DIG_W-1:0]    dig;
  logic [DGB-1:0]      mb_dig;
  logic [DW+DGB-1:0]   pp;
  logic [ACC_W-1:0]    acc, acc_next, rnd, q;
  logic [DW-1:0]       lim, rl, res, pm;
  logic [SUM_W-1:0]    sum_next;
  logic [DW:0]         diff;

  // Output conversion.
  logic [RM_W-1:0]        rm, rm_calc, lim_s, rs;
  logic                   clip_calc;
  logic [SAMPLE_BITS-1:0] samp_calc;

  // Output register.
  logic [CB-1:0]          out_chan;
  logic [SAMPLE_BITS-1:0] out_sample;
  logic                   out_clip;

  // RAM interface.
  logic [ROW_W-1:0] ram_rdata;
  logic [ROW_W-1:0] ram_wdata;

  // Channel number to RAM row: a constant table, one entry per channel code.
  logic [IDX_W-1:0] mod_tab [boae_pkg::CHANNEL_CODES];

  for (genvar g = 0; g < boae_pkg::CHANNEL_CODES; g++) begin : g_mod
    localparam int ROW = g % CHANNELS;
    assign mod_tab[g] = IDX_W'(ROW);
  end

  assign in_fire = s_tvalid && s_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      input_gain      <= '0;
      coef_prev_input <= '0;
      coef_prev_disp  <= '0;
      coef_older_disp <= '0;
      coef_cubic      <= '0;
      velocity_scale  <= '0;
      output_gain     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        boae_pkg::REG_INPUT_GAIN:      input_gain      <= cfg_data;
        boae_pkg::REG_COEF_PREV_INPUT: coef_prev_input <= cfg_data;
        boae_pkg::REG_COEF_PREV_DISP:  coef_prev_disp  <= cfg_data;
        boae_pkg::REG_COEF_OLDER_DISP: coef_older_disp <= cfg_data;
        boae_pkg::REG_COEF_CUBIC:      coef_cubic      <= cfg_data;
        boae_pkg::REG_VELOCITY_SCALE:  velocity_scale  <= cfg_data;
        boae_pkg::REG_OUTPUT_GAIN:     output_gain     <= cfg_data;
        default: ;
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= boae_pkg::ST_IDLE;
      prod  <= boae_pkg::PR_IN;
    end else begin
      state <= state_next;
      prod  <= prod_next;
    end
  end

  // Next state and sequencer outputs.
  always_comb begin
    state_next = state;
    prod_next  = prod;
    s_tready   = 1'b0;
    done_fire  = 1'b0;
    unique case (state)
      boae_pkg::ST_IDLE: begin
        // No item is taken while reset is held.
        s_tready = !rst;
        if (s_tvalid) begin
          state_next = boae_pkg::ST_FETCH;
        end
      end
      boae_pkg::ST_FETCH: begin
        prod_next  = boae_pkg::PR_IN;
        state_next = boae_pkg::ST_LOAD;
      end
      boae_pkg::ST_LOAD: begin
        state_next = boae_pkg::ST_MUL;
      end
      boae_pkg::ST_MUL: begin
        if (dig == DIG_W'(NDIG - 1)) begin
          state_next = boae_pkg::ST_FIN;
        end
      end
      boae_pkg::ST_FIN: begin
        unique case (prod)
          boae_pkg::PR_IN:   prod_next = boae_pkg::PR_SQ;
          boae_pkg::PR_SQ:   prod_next = boae_pkg::PR_CUBE;
          boae_pkg::PR_CUBE: prod_next = boae_pkg::PR_CCUB;
          boae_pkg::PR_CCUB: prod_next = boae_pkg::PR_CIN;
          boae_pkg::PR_CIN:  prod_next = boae_pkg::PR_CPD;
          boae_pkg::PR_CPD:  prod_next = boae_pkg::PR_COD;
          boae_pkg::PR_COD:  prod_next = boae_pkg::PR_VEL;
          boae_pkg::PR_VEL:  prod_next = boae_pkg::PR_OUT;
          boae_pkg::PR_OUT:  prod_next = boae_pkg::PR_OUT;
          default:           prod_next = boae_pkg::PR_IN;
        endcase
        if (prod == boae_pkg::PR_COD) begin
          state_next = boae_pkg::ST_SUMSAT;
        end else if (prod == boae_pkg::PR_OUT) begin
          state_next = boae_pkg::ST_CONV;
        end else begin
          state_next = boae_pkg::ST_LOAD;
        end
      end
      boae_pkg::ST_SUMSAT: begin
        state_next = boae_pkg::ST_DIFF;
      end
      boae_pkg::ST_DIFF: begin
        state_next = boae_pkg::ST_LOAD;
      end
      boae_pkg::ST_CONV: begin
        state_next = boae_pkg::ST_DONE;
      end
      boae_pkg::ST_DONE: begin
        // Hold the finished result until the output register is free.
        if (!m_tvalid || m_tready) begin
          done_fire  = 1'b1;
          state_next = boae_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = boae_pkg::ST_IDLE;
      end
    endcase
  end

  // Operand selection for the product now being loaded.
  always_comb begin
    case (prod)
      boae_pkg::PR_IN: begin
        opa = {{(DW-SAMPLE_BITS){smp_r[SAMPLE_BITS-1]}}, smp_r};
        opb = input_gain;
      end
      boae_pkg::PR_SQ: begin
        opa = x1;
        opb = x1;
      end
      boae_pkg::PR_CUBE: begin
        opa = t;
        opb = x1;
      end
      boae_pkg::PR_CCUB: begin
        opa = coef_cubic;
        opb = t;
      end
      boae_pkg::PR_CIN: begin
        opa = coef_prev_input;
        opb = u1;
      end
      boae_pkg::PR_CPD: begin
        opa = coef_prev_disp;
        opb = x1;
      end
      boae_pkg::PR_COD: begin
        opa = coef_older_disp;
        opb = x2;
      end
      boae_pkg::PR_VEL: begin
        opa = t;
        opb = velocity_scale;
      end
      boae_pkg::PR_OUT: begin
        opa = t;
        opb = output_gain;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Magnitude product, one digit of mb per cycle. The accumulator starts
  // from the rounding constant, so the final shift rounds half away from zero.
  assign mb_dig   = mb[DGB*dig +: DGB];
  assign pp       = ma * mb_dig;
  assign rnd      = sh_in ? (ACC_W'(1) << (IN_SH - 1)) : (ACC_W'(1) << (FRAC_BITS - 1));
  assign acc_next = ((dig == '0) ? rnd : acc) + (ACC_W'(pp) << (DGB * dig));

  // Shift, saturate the magnitude, then apply the sign.
  assign q        = sh_in ? (acc >> IN_SH) : (acc >> FRAC_BITS);
  assign lim      = pneg ? MAG_NEG : MAG_POS;
  assign rl       = (q > ACC_W'(lim)) ? lim : q[DW-1:0];
  assign res      = pneg ? (DW'(0) - rl) : rl;
  assign sum_next = pneg ? (sum - SUM_W'(rl)) : (sum + SUM_W'(rl));
  assign diff     = {x0[DW-1], x0} - {x1[DW-1], x1};

  // Output conversion from the magnitude of the last product.
  if (OUT_SH > 0) begin : g_round_down
    assign rm_calc = (RM_W'(pm) + (RM_W'(1) << (OUT_SH - 1))) >> OUT_SH;
  end else begin : g_shift_up
    assign rm_calc = RM_W'(pm) << OUT_LSH;
  end

  assign lim_s     = pneg ? (RM_W'(1) << (SAMPLE_BITS - 1))
                          : ((RM_W'(1) << (SAMPLE_BITS - 1)) - RM_W'(1));
  assign clip_calc = rm > lim_s;
  assign rs        = clip_calc ? lim_s : rm;
  assign samp_calc = pneg ? (SAMPLE_BITS'(0) - rs[SAMPLE_BITS-1:0]) : rs[SAMPLE_BITS-1:0];

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      chan_r <= s_tdata[CB-1:0];
      smp_r  <= s_tdata[CB +: SAMPLE_BITS];
      ci     <= mod_tab[s_tdata[CB-1:0]];
    end
    case (state)
      boae_pkg::ST_FETCH: begin
        // A row never written since reset reads as zero.
        if (row_valid[ci]) begin
          x1 <= ram_rdata[0 +: DW];
          x2 <= ram_rdata[DW +: DW];
          u1 <= ram_rdata[2*DW +: DW];
        end else begin
          x1 <= '0;
          x2 <= '0;
          u1 <= '0;
        end
        sum <= '0;
      end
      boae_pkg::ST_LOAD: begin
        ma    <= mag_of(opa);
        mb    <= mag_of(opb);
        pneg  <= opa[DW-1] ^ opb[DW-1];
        sh_in <= (prod == boae_pkg::PR_IN);
        dig   <= '0;
      end
      boae_pkg::ST_MUL: begin
        acc <= acc_next;
        dig <= dig + DIG_W'(1);
      end
      boae_pkg::ST_FIN: begin
        pm <= rl;
        case (prod) inside
          boae_pkg::PR_IN: u_new <= res;
          boae_pkg::PR_SQ, boae_pkg::PR_CUBE, boae_pkg::PR_VEL: t <= res;
          boae_pkg::PR_CCUB, boae_pkg::PR_CIN, boae_pkg::PR_CPD, boae_pkg::PR_COD:
            sum <= sum_next;
          default: ;
        endcase
      end
      boae_pkg::ST_SUMSAT: begin
        x0 <= sat_data(sum);
      end
      boae_pkg::ST_DIFF: begin
        t <= sat_data({diff[DW], diff});
      end
      boae_pkg::ST_CONV: begin
        rm <= rm_calc;
      end
      default: ;
    endcase
    if (done_fire) begin
      out_chan   <= chan_r;
      out_sample <= samp_calc;
      out_clip   <= clip_calc;
    end
  end

  // Output valid and per-row valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      row_valid <= '0;
    end else begin
      if (done_fire) begin
        m_tvalid      <= 1'b1;
        row_valid[ci] <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    m_tdata                       = '0;
    m_tdata[0 +: CB]              = out_chan;
    m_tdata[CB +: SAMPLE_BITS]    = out_sample;
  end
  assign m_tuser = out_clip;

  // Row layout: last displacement, older displacement, scaled input.
  assign ram_wdata = {u_new, x1, x0};

  boae_ram #(
    .WIDTH (ROW_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (done_fire),
    .waddr (ci),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (mod_tab[s_tdata[CB-1:0]]),
    .rdata (ram_rdata)
  );

  // An accepted item always starts with the state read.
  a_accept_fetch: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == boae_pkg::ST_FETCH)
    else $error("accepted item did not start the state read");

  // A new result only appears from the final sequencer step.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == boae_pkg::ST_DONE)
    else $error("result appeared outside the final step");

  // Writing a channel row goes with loading a result and marks the row valid.
  a_row_write: assert property (@(posedge clk) disable iff (rst)
    done_fire |=> m_tvalid && (row_valid != '0))
    else $error("state write without a result");

  // The multiplier never starts while the block still takes items.
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state == boae_pkg::ST_MUL) |-> !s_tready)
    else $error("ready while the multiplier runs");

endmodule

// ===== design/boae_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the per-channel oscillator state; no dependencies.
module boae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
